/* sv/plti_pkg.sv */
// ----------------------------------------------------------------------------
// plti_pkg: shared constants and types for the table interpolator
// Sizes of the breakpoint table, operand widths of the serial arithmetic
// units and the status bundle that those units return.
// ----------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

  // table geometry
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // field widths
  localparam int PC_W   = 5;
  localparam int DATA_W = 16;

  // serial arithmetic widths
  localparam int MAG_W      = DATA_W;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int MUL_STEPS  = MAG_W;
  localparam int MUL_CNT_W  = $clog2(MUL_STEPS);
  localparam int DIV_CYCLES = PROD_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // reset value of the point count register
  localparam logic [PC_W-1:0] PC_RESET = PC_W'(MAX_POINTS);

  // request opcodes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // status of a serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

/* sv/plti_table.sv */
// ----------------------------------------------------------------------------
// plti_table: breakpoint store
// Two arrays for breakpoint x and y with separate write and read ports,
// one write and one registered read per cycle, sharing the same addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_table (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [plti_pkg::IDX_W-1:0]   wr_addr,
  input  wire logic [plti_pkg::DATA_W-1:0]  wr_x,
  input  wire logic [plti_pkg::DATA_W-1:0]  wr_y,
  input  wire logic [plti_pkg::IDX_W-1:0]   rd_addr,
  output logic      [plti_pkg::DATA_W-1:0]  rd_x,
  output logic      [plti_pkg::DATA_W-1:0]  rd_y
);
  import plti_pkg::*;

  logic [DATA_W-1:0] x_mem [MAX_POINTS];
  logic [DATA_W-1:0] y_mem [MAX_POINTS];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/plti_mul.sv */
// ----------------------------------------------------------------------------
// plti_mul: bit-serial unsigned multiplier
// Shift-and-add over the multiplier one bit per cycle; only a narrow adder
// sits between registers.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_mul (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [plti_pkg::MAG_W-1:0]   mcand,
  input  wire logic [plti_pkg::MAG_W-1:0]   mplier,
  output plti_pkg::unit_stat_t              stat,
  output logic      [plti_pkg::PROD_W-1:0]  product
);
  import plti_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [MAG_W-1:0]     mcand_r;
  logic [MAG_W-1:0]     hi_r;
  logic [MAG_W-1:0]     lo_r;
  logic [MAG_W:0]       sum_nxt;

  // partial product add for the current multiplier bit
  always_comb begin
    sum_nxt = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CNT_W'(MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // accumulator shifts right one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (busy_r) begin
      hi_r <= sum_nxt[MAG_W:1];
      lo_r <= {sum_nxt[0], lo_r[MAG_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = {hi_r, lo_r};

endmodule

`default_nettype wire

/* sv/plti_div.sv */
// ----------------------------------------------------------------------------
// plti_div: serial unsigned divider
// Restoring division, two quotient bits per cycle; the quotient shifts in
// behind the dividend in the same register.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [plti_pkg::PROD_W-1:0]  dividend,
  input  wire logic [plti_pkg::MAG_W-1:0]   divisor,
  output plti_pkg::unit_stat_t              stat,
  output logic      [plti_pkg::PROD_W-1:0]  quotient
);
  import plti_pkg::*;

  // one restoring step: returns {remainder, shifted dividend/quotient}
  function automatic logic [MAG_W+PROD_W-1:0] div_step(
    input logic [MAG_W-1:0]  rem,
    input logic [PROD_W-1:0] dq,
    input logic [MAG_W-1:0]  d
  );
    logic [MAG_W:0] trial;
    logic [MAG_W:0] diff;
    trial = {rem, dq[PROD_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[MAG_W-1:0], dq[PROD_W-2:0], 1'b1};
    end else begin
      div_step = {trial[MAG_W-1:0], dq[PROD_W-2:0], 1'b0};
    end
  endfunction

  logic                      busy_r;
  logic                      done_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic [MAG_W-1:0]          d_r;
  logic [MAG_W-1:0]          rem_r;
  logic [PROD_W-1:0]         dq_r;
  logic [MAG_W+PROD_W-1:0]   step1;
  logic [MAG_W+PROD_W-1:0]   step2;

  // two chained steps per cycle
  always_comb begin
    step1 = div_step(rem_r, dq_r, d_r);
    step2 = div_step(step1[MAG_W+PROD_W-1:PROD_W], step1[PROD_W-1:0], d_r);
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend/quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= divisor;
      rem_r <= '0;
      dq_r  <= dividend;
    end else if (busy_r) begin
      rem_r <= step2[MAG_W+PROD_W-1:PROD_W];
      dq_r  <= step2[PROD_W-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

`default_nettype wire

/* sv/piecewise_linear_table_interp.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp: breakpoint table with linear interpolation
// A load request writes one (x, y) breakpoint; a query request returns y
// interpolated on the segment holding x (x Q8.8, y Q4.12), truncated toward
// zero and saturated to 16 bits, with flags for out of span, clipping and a
// non-ascending table. One request is handled at a time. Every request scans
// the n used table entries through the single read port; a query inside the
// span with a non-zero segment width then runs a bit-serial multiply and a
// two-bit-per-cycle divide, which a load, an out-of-span query or a
// zero-width segment skips. A finished result waits in the output register
// until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic        [plti_pkg::PC_W-1:0]   cfg_wr_data,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_op,
  input  wire logic        [3:0]                  in_entry_index,
  input  wire logic signed [plti_pkg::DATA_W-1:0] in_point_x,
  input  wire logic signed [plti_pkg::DATA_W-1:0] in_point_y,
  // result channel
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed      [plti_pkg::DATA_W-1:0] out_result_y,
  output logic                                    out_out_of_range,
  output logic                                    out_table_unordered,
  output logic                                    out_saturated
);
  import plti_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_EVAL = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // magnitude of a 17-bit signed difference
  function automatic logic [MAG_W-1:0] mag17(input logic signed [DATA_W:0] v);
    logic signed [DATA_W:0] neg;
    neg = -v;
    mag17 = v[DATA_W] ? neg[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  state_t                    state_r, state_nxt;
  logic [PC_W-1:0]           point_count_r;
  logic [CNT_W-1:0]          n_used;
  logic [CNT_W-1:0]          k_r;
  logic                      dv_r;
  logic [IDX_W-1:0]          dk_r;
  logic                      issue;
  logic                      last_data;

  logic                      op_r;
  logic signed [DATA_W-1:0]  q_r;
  logic signed [DATA_W-1:0]  first_x_r;
  logic signed [DATA_W-1:0]  prev_x_r;
  logic signed [DATA_W-1:0]  x0_r, x1_r, y0_r, y1_r;
  logic                      pend_r;
  logic                      unord_r;
  logic                      oor_r;
  logic                      neg_r;
  logic [MAG_W-1:0]          sp_mag_r;
  logic [PROD_W-1:0]         quot_r;

  logic [DATA_W-1:0]         tbl_rx, tbl_ry;
  logic signed [DATA_W-1:0]  cur_x, cur_y;
  logic signed [DATA_W:0]    dx_w, dy_w, sp_w;
  logic                      no_interp;
  logic                      mul_start, div_start;
  unit_stat_t                mul_stat, div_stat;
  logic [PROD_W-1:0]         mul_prod, div_quot;
  logic signed [PROD_W+1:0]  qsigned, val_w;
  logic                      sat_hi, sat_lo;
  logic                      out_load;

  logic                      out_valid_r;
  logic signed [DATA_W-1:0]  out_result_y_r;
  logic                      out_of_range_r, out_unordered_r, out_saturated_r;

  // used point count, clamped into the legal span
  always_comb begin
    if (int'(point_count_r) < 2) begin
      n_used = CNT_W'(2);
    end else if (int'(point_count_r) > MAX_POINTS) begin
      n_used = CNT_W'(MAX_POINTS);
    end else begin
      n_used = CNT_W'(point_count_r);
    end
  end

  // breakpoint store
  plti_table u_table (
    .clk     (clk),
    .wr_en   (in_valid && in_ready && (in_op == OP_LOAD)
              && (int'(in_entry_index) < MAX_POINTS)),
    .wr_addr (IDX_W'(in_entry_index)),
    .wr_x    (in_point_x),
    .wr_y    (in_point_y),
    .rd_addr (k_r[IDX_W-1:0]),
    .rd_x    (tbl_rx),
    .rd_y    (tbl_ry)
  );

  assign cur_x     = $signed(tbl_rx);
  assign cur_y     = $signed(tbl_ry);
  assign issue     = (state_r == S_SCAN) && (k_r < n_used);
  assign last_data = dv_r && ({1'b0, dk_r} == CNT_W'(n_used - 1'b1));

  // segment differences for the interpolation
  always_comb begin
    dx_w      = {q_r[DATA_W-1], q_r} - {x0_r[DATA_W-1], x0_r};
    dy_w      = {y1_r[DATA_W-1], y1_r} - {y0_r[DATA_W-1], y0_r};
    sp_w      = {x1_r[DATA_W-1], x1_r} - {x0_r[DATA_W-1], x0_r};
    no_interp = (op_r == OP_LOAD) || oor_r || (sp_w == '0);
  end

  assign mul_start = (state_r == S_EVAL) && !no_interp;
  assign div_start = (state_r == S_MUL) && mul_stat.done;

  plti_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mag17(dx_w)),
    .mplier  (mag17(dy_w)),
    .stat    (mul_stat),
    .product (mul_prod)
  );

  plti_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mul_prod),
    .divisor  (sp_mag_r),
    .stat     (div_stat),
    .quotient (div_quot)
  );

  // final sum and saturation
  always_comb begin
    qsigned = neg_r ? -$signed({2'b00, quot_r}) : $signed({2'b00, quot_r});
    val_w   = {{(PROD_W+2-DATA_W){y0_r[DATA_W-1]}}, y0_r} + qsigned;
    sat_hi  = val_w > $signed((PROD_W+2)'(32767));
    sat_lo  = val_w < -$signed((PROD_W+2)'(32768));
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: if (last_data) state_nxt = S_EVAL;
      S_EVAL: state_nxt = no_interp ? S_DONE : S_MUL;
      S_MUL:  if (mul_stat.done) state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      point_count_r <= PC_RESET;
      k_r           <= '0;
      dv_r          <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        point_count_r <= cfg_wr_data;
      end
      if (in_valid && in_ready) begin
        k_r <= '0;
      end else if (issue) begin
        k_r <= k_r + 1'b1;
      end
      dv_r <= issue;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, table scan and arithmetic operands
  always_ff @(posedge clk) begin
    dk_r <= k_r[IDX_W-1:0];
    if (in_valid && in_ready) begin
      op_r    <= in_op;
      q_r     <= in_point_x;
      pend_r  <= 1'b0;
      unord_r <= 1'b0;
    end
    // one table entry per cycle
    if ((state_r == S_SCAN) && dv_r) begin
      if (dk_r == '0) begin
        first_x_r <= cur_x;
      end else if (prev_x_r > cur_x) begin
        unord_r <= 1'b1;
      end
      prev_x_r <= cur_x;
      if (pend_r) begin
        x1_r <= cur_x;
        y1_r <= cur_y;
      end
      if (!last_data && (cur_x <= q_r)) begin
        x0_r   <= cur_x;
        y0_r   <= cur_y;
        pend_r <= 1'b1;
      end else begin
        pend_r <= 1'b0;
      end
      if (last_data) begin
        oor_r <= (q_r < ((dk_r == '0) ? cur_x : first_x_r)) || (q_r > cur_x);
      end
    end
    // segment set-up
    if (state_r == S_EVAL) begin
      quot_r   <= '0;
      neg_r    <= dx_w[DATA_W] ^ dy_w[DATA_W] ^ sp_w[DATA_W];
      sp_mag_r <= mag17(sp_w);
      if ((op_r == OP_LOAD) || oor_r) begin
        y0_r <= '0;
      end
    end
    if ((state_r == S_DIV) && div_stat.done) begin
      quot_r <= div_quot;
    end
    // output register
    if (out_load) begin
      out_result_y_r  <= sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : val_w[DATA_W-1:0]);
      out_saturated_r <= sat_hi || sat_lo;
      out_of_range_r  <= (op_r == OP_QUERY) && oor_r;
      out_unordered_r <= unord_r;
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_result_y        = out_result_y_r;
  assign out_out_of_range    = out_of_range_r;
  assign out_table_unordered = out_unordered_r;
  assign out_saturated       = out_saturated_r;

endmodule

`default_nettype wire

/* sv/plti_checker.sv */
// ----------------------------------------------------------------------------
// plti_checker: port-level checks for the table interpolator
// Watches the request and result channels of the top level and is attached
// to it by the bind at the foot of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_result_y,
  input wire logic        out_out_of_range,
  input wire logic        out_saturated
);

  // one request at a time: an accepted request blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_y))
    else $error("stalled result changed or dropped");

  // out of span gives a zero, unclipped result
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> (out_result_y == 16'h0000) && !out_saturated)
    else $error("out of range result not zero");

  // a clipped result sits on a rail
  a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_result_y == 16'h7fff) || (out_result_y == 16'h8000))
    else $error("saturated result off the rails");

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_y     (out_result_y),
  .out_out_of_range (out_out_of_range),
  .out_saturated    (out_saturated)
);

`default_nettype wire
